FILE: rtl/core/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the sample-playback mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

   localparam int VOICE_COUNT_DEF  = 64;
   localparam int SOUND_COUNT_DEF  = 64;
   localparam int SAMPLE_DEPTH_DEF = 65536;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 6;
   localparam int SADDR_W  = 16;
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 17;

   typedef enum logic [1:0] {
      CMD_TICK         = 2'd0,
      CMD_PLAY         = 2'd1,
      CMD_WRITE_SAMPLE = 2'd2,
      CMD_WRITE_SOUND  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SOUND_RD,
      ST_PLAY_SCAN,
      ST_PLAY_LOAD,
      ST_MIX_RD,
      ST_MIX_SAMP,
      ST_MIX_ACC,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch request fields
      logic sound_rd;     // read sound table
      logic scan_clear;   // reset voice counter
      logic scan_step;    // advance voice counter
      logic play_load;    // load found voice
      logic mix_rd;       // read voice state
      logic mix_samp;     // read sample at voice position
      logic mix_acc;      // accumulate and update voice
      logic sample_wr;    // write sample memory
      logic sound_wr;     // write sound table
      logic respond;      // present result
      logic refused;      // play refused
      logic played;       // play succeeded
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    id_ok;     // sound id in range
      logic    last;      // voice counter at final voice
      logic    idle_hit;  // current voice idle
   } stat_type;

endpackage

FILE: rtl/core/multi_voice_sample_mixer_top.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_top
// Sample-playback mixer with a voice pool, sound table and sample memory.
// ----------------------------------------------------------------------------
// Usage: drive req_* fields and raise start while busy is low; the request
// is taken at that edge. Commands: tick mixes one output sample, play takes
// the lowest idle voice, write sample fills the sample memory, write sound
// sets a sound's begin and exclusive end.
// Each request gives exactly one result, shown on rsp_* for one cycle with
// rsp_valid high; the receiver cannot stall and must take it then.
// A tick works through the voices in turn: for each voice it reads the
// position, limit and busy flag, then reads the sample memory at that
// position, then accumulates. busy stays high until the result is shown, so
// requests run one at a time; the next one can be taken in the result cycle.
// Reset clears all voices to idle; position and limit load at each play.
// Sample memory and sound table hold undefined data until written. No
// clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_top #(
   parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
   parameter int SOUND_COUNT  = mvsm_pkg::SOUND_COUNT_DEF,
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mvsm_pkg::CMD_W-1:0]            req_cmd,
   input  logic [mvsm_pkg::ID_W-1:0]             req_sound_id,
   input  logic [mvsm_pkg::SADDR_W-1:0]          req_sample_address,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [mvsm_pkg::POS_W-1:0]            req_range_begin,
   input  logic [mvsm_pkg::POS_W-1:0]            req_range_end,
   output logic                                  rsp_valid,
   output logic signed [mvsm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic [mvsm_pkg::ID_W-1:0]             rsp_voice_index,
   output logic                                  rsp_status
);

   mvsm_pkg::ctrl_type ctrl;
   mvsm_pkg::stat_type stat;

   mvsm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   mvsm_datapath #(
      .VOICE_COUNT  (VOICE_COUNT),
      .SOUND_COUNT  (SOUND_COUNT),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_cmd            (req_cmd),
      .req_sound_id       (req_sound_id),
      .req_sample_address (req_sample_address),
      .req_sample_value   (req_sample_value),
      .req_range_begin    (req_range_begin),
      .req_range_end      (req_range_end),
      .rsp_valid          (rsp_valid),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .rsp_voice_index    (rsp_voice_index),
      .rsp_status         (rsp_status)
   );

endmodule

FILE: rtl/core/mvsm_ctrl.sv
// ----------------------------------------------------------------------------
// mvsm_ctrl
// Controller: sequences one request through the datapath.
// ----------------------------------------------------------------------------
module mvsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mvsm_pkg::stat_type  stat,
   output mvsm_pkg::ctrl_type  ctrl
);

   mvsm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvsm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = (state_ff != mvsm_pkg::ST_IDLE);
      case (state_ff)
         mvsm_pkg::ST_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               state_in     = mvsm_pkg::ST_SOUND_RD;
            end
         end
         mvsm_pkg::ST_SOUND_RD: begin
            ctrl.scan_clear = 1'b1;
            case (stat.cmd)
               mvsm_pkg::CMD_TICK: state_in = mvsm_pkg::ST_MIX_RD;
               mvsm_pkg::CMD_PLAY: begin
                  ctrl.sound_rd = 1'b1;
                  state_in = stat.id_ok ? mvsm_pkg::ST_PLAY_SCAN : mvsm_pkg::ST_DONE;
               end
               mvsm_pkg::CMD_WRITE_SAMPLE: begin
                  ctrl.sample_wr = 1'b1;
                  state_in = mvsm_pkg::ST_DONE;
               end
               default: begin
                  ctrl.sound_wr = 1'b1;
                  state_in = mvsm_pkg::ST_DONE;
               end
            endcase
         end
         mvsm_pkg::ST_PLAY_SCAN: begin
            if (stat.idle_hit) begin
               state_in = mvsm_pkg::ST_PLAY_LOAD;
            end else if (stat.last) begin
               ctrl.refused = 1'b1;
               state_in = mvsm_pkg::ST_DONE;
            end else begin
               ctrl.scan_step = 1'b1;
            end
         end
         mvsm_pkg::ST_PLAY_LOAD: begin
            ctrl.play_load = 1'b1;
            ctrl.played    = 1'b1;
            state_in = mvsm_pkg::ST_DONE;
         end
         mvsm_pkg::ST_MIX_RD: begin
            ctrl.mix_rd = 1'b1;
            state_in = mvsm_pkg::ST_MIX_SAMP;
         end
         mvsm_pkg::ST_MIX_SAMP: begin
            ctrl.mix_samp = 1'b1;
            state_in = mvsm_pkg::ST_MIX_ACC;
         end
         mvsm_pkg::ST_MIX_ACC: begin
            ctrl.mix_acc = 1'b1;
            if (stat.last) begin
               state_in = mvsm_pkg::ST_DONE;
            end else begin
               ctrl.scan_step = 1'b1;
               state_in = mvsm_pkg::ST_MIX_RD;
            end
         end
         mvsm_pkg::ST_DONE: begin
            ctrl.respond = 1'b1;
            state_in = mvsm_pkg::ST_IDLE;
         end
         default: state_in = mvsm_pkg::ST_IDLE;
      endcase
   end

   a_one_wr: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.sample_wr && ctrl.sound_wr)) else $error("two writes at once");
   a_done_after: assert property (@(posedge clock) disable iff (reset)
      ctrl.respond |=> !busy) else $error("not idle after result");
   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |-> !busy) else $error("capture while busy");
   a_refuse_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.refused && ctrl.played)) else $error("refused and played");

endmodule

FILE: rtl/core/mvsm_datapath.sv
// ----------------------------------------------------------------------------
// mvsm_datapath
// Datapath: sample memory, sound table, voice state, mix accumulator.
// ----------------------------------------------------------------------------
module mvsm_datapath #(
   parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
   parameter int SOUND_COUNT  = mvsm_pkg::SOUND_COUNT_DEF,
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mvsm_pkg::ctrl_type                    ctrl,
   output mvsm_pkg::stat_type                    stat,
   input  logic [mvsm_pkg::CMD_W-1:0]            req_cmd,
   input  logic [mvsm_pkg::ID_W-1:0]             req_sound_id,
   input  logic [mvsm_pkg::SADDR_W-1:0]          req_sample_address,
   input  logic signed [mvsm_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [mvsm_pkg::POS_W-1:0]            req_range_begin,
   input  logic [mvsm_pkg::POS_W-1:0]            req_range_end,
   output logic                                  rsp_valid,
   output logic signed [mvsm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic [mvsm_pkg::ID_W-1:0]             rsp_voice_index,
   output logic                                  rsp_status
);

   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SW = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int PW = mvsm_pkg::POS_W;
   localparam int DW = mvsm_pkg::SAMPLE_W;

   // request registers
   mvsm_pkg::cmd_type                  cmd_ff;
   logic [mvsm_pkg::ID_W-1:0]          id_ff;
   logic [mvsm_pkg::SADDR_W-1:0]       saddr_ff;
   logic [DW-1:0]                      sval_ff;
   logic [PW-1:0]                      rbeg_ff, rend_ff;

   // stores
   logic [DW-1:0] sample_mem [SAMPLE_DEPTH];
   logic [PW-1:0] snd_start_mem [SOUND_COUNT];
   logic [PW-1:0] snd_stop_mem  [SOUND_COUNT];
   logic [PW-1:0] pos_mem [VOICE_COUNT];
   logic [PW-1:0] lim_mem [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] busy_ff;

   logic [PW-1:0] snd_start_ff, snd_stop_ff;
   logic [VW-1:0] vidx_ff;
   logic [PW-1:0] vpos_ff, vlim_ff;
   logic          vbusy_ff;
   logic [DW-1:0] samp_ff;
   logic          in_range_ff;
   logic signed [DW-1:0] acc_ff;
   logic          refused_ff;
   logic [mvsm_pkg::ID_W-1:0] vout_ff;

   logic          id_ok;
   logic [SW-1:0] sid;
   logic [AW-1:0] rd_addr;
   logic signed [DW+1:0] sum;
   logic signed [DW-1:0] sat;

   assign id_ok = ({{(32-mvsm_pkg::ID_W){1'b0}}, id_ff} < 32'(SOUND_COUNT));
   assign sid   = SW'(id_ff);
   assign stat.cmd      = cmd_ff;
   assign stat.id_ok    = id_ok;
   assign stat.last     = ({{(32-VW){1'b0}}, vidx_ff} == 32'(VOICE_COUNT - 1));
   assign stat.idle_hit = !busy_ff[vidx_ff];

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= mvsm_pkg::cmd_type'(req_cmd);
         id_ff    <= req_sound_id;
         saddr_ff <= req_sample_address;
         sval_ff  <= req_sample_value;
         rbeg_ff  <= req_range_begin;
         rend_ff  <= req_range_end;
      end
      if (ctrl.sample_wr && ({{(32-mvsm_pkg::SADDR_W){1'b0}}, saddr_ff} < 32'(SAMPLE_DEPTH)))
         sample_mem[AW'(saddr_ff)] <= sval_ff;
      if (ctrl.sound_wr && id_ok) begin
         snd_start_mem[sid] <= rbeg_ff;
         snd_stop_mem[sid]  <= rend_ff;
      end
      if (ctrl.sound_rd) begin
         snd_start_ff <= snd_start_mem[sid];
         snd_stop_ff  <= snd_stop_mem[sid];
      end
      if (ctrl.mix_samp) begin
         samp_ff     <= sample_mem[rd_addr];
         in_range_ff <= ({{(32-PW){1'b0}}, vpos_ff} < 32'(SAMPLE_DEPTH));
      end
   end

   assign rd_addr = AW'(vpos_ff);

   // position and limit load at every play, so only the busy flags need reset
   always_ff @(posedge clock) begin
      if (ctrl.play_load) begin
         pos_mem[vidx_ff] <= snd_start_ff;
         lim_mem[vidx_ff] <= snd_stop_ff;
      end else if (ctrl.mix_acc && vbusy_ff && (vpos_ff != vlim_ff)) begin
         pos_mem[vidx_ff] <= vpos_ff + 1'b1;
      end
      if (ctrl.mix_rd) begin
         vpos_ff  <= pos_mem[vidx_ff];
         vlim_ff  <= lim_mem[vidx_ff];
         vbusy_ff <= busy_ff[vidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (ctrl.play_load) begin
         busy_ff[vidx_ff] <= 1'b1;
      end else if (ctrl.mix_acc && vbusy_ff && (vpos_ff == vlim_ff)) begin
         busy_ff[vidx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vidx_ff <= '0;
      end else if (ctrl.scan_clear) begin
         vidx_ff <= '0;
      end else if (ctrl.scan_step) begin
         vidx_ff <= vidx_ff + 1'b1;
      end
   end

   assign sum = (DW+2)'(acc_ff) + (DW+2)'($signed(in_range_ff ? samp_ff : '0));
   always_comb begin
      if (sum > (DW+2)'(32767)) sat = 16'sh7fff;
      else if (sum < -(DW+2)'(32768)) sat = 16'sh8000;
      else sat = DW'(sum);
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         acc_ff     <= '0;
         refused_ff <= 1'b0;
         vout_ff    <= '0;
      end else begin
         if (ctrl.mix_acc && vbusy_ff && (vpos_ff != vlim_ff)) acc_ff <= sat;
         if (ctrl.refused) refused_ff <= 1'b1;
         if (ctrl.played)  vout_ff <= mvsm_pkg::ID_W'(vidx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= ctrl.respond;
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_mixed_sample <= (cmd_ff == mvsm_pkg::CMD_TICK) ? acc_ff : '0;
         rsp_voice_index  <= vout_ff;
         rsp_status       <= refused_ff;
      end
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.play_load |-> !busy_ff[vidx_ff]) else $error("load into busy voice");
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.play_load |=> busy_ff[$past(vidx_ff)]) else $error("voice not marked");
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_voice_index == '0) else $error("bad refuse");

endmodule
